@@ rtl/bdba_pkg.sv @@
// Package for the bitmap disk block allocator: geometry defaults, field widths
// and status codes. Used by bitmap_disk_block_allocator_unit; no dependencies.
package bdba_pkg;

  localparam int unsigned Cylinders = 8;
  localparam int unsigned Tracks    = 2;
  localparam int unsigned Sectors   = 4;

  localparam int unsigned CylW     = 3;
  localparam int unsigned TrackW   = 1;
  localparam int unsigned SectorW  = 2;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned AddrW    = CylW + TrackW + SectorW;
  localparam int unsigned DataW    = ((AddrW + 7) / 8) * 8;

  typedef enum logic [0:0] {
    ReqAlloc = 1'b0,
    ReqFree  = 1'b1
  } req_e;

  typedef enum logic [StatusW-1:0] {
    StOk        = 2'd0,
    StFull      = 2'd1,
    StNotAlloc  = 2'd2
  } status_e;

endpackage

@@ rtl/bitmap_disk_block_allocator_unit.sv @@
// Bitmap disk block allocator: used map in a one-row-per-cylinder RAM with a
// lowest-non-full-cylinder hint. Depends on bdba_pkg.
//
//  channel  | dir | tuser            | tdata (low bit up)
//  s_axis   | in  | req_type         | cyl_in, track_in, sector_in, zero pad
//  m_axis   | out | status           | cyl_out, track_out, sector_out, zero pad
//
// An allocate reads the hint cylinder's row and, if it has a free block, writes
// it back with that block set; it reads one more row per full cylinder it steps
// over, and when the steps run past the last cylinder the disk-full result comes
// with no further read. An in-range free reads its row, then writes back if set;
// an out-of-range free, or an allocate whose hint is past the end, reads no row.
// After reset a clearing pass writes zero to all CYLINDERS rows, one per cycle,
// before the first request is taken. A stalled result holds in the output
// register; the next request is taken as that result is taken.
module bitmap_disk_block_allocator_unit #(
  parameter int unsigned CYLINDERS = bdba_pkg::Cylinders,
  parameter int unsigned TRACKS    = bdba_pkg::Tracks,
  parameter int unsigned SECTORS   = bdba_pkg::Sectors
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [bdba_pkg::DataW-1:0]    s_axis_tdata_i,   // cyl_in, track_in, sector_in
  input  logic                          s_axis_tuser_i,   // req_type
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [bdba_pkg::DataW-1:0]    m_axis_tdata_o,   // cyl_out, track_out, sector_out
  output logic [bdba_pkg::StatusW-1:0]  m_axis_tuser_o    // status
);

  localparam int unsigned RowW   = TRACKS * SECTORS;
  localparam int unsigned CylAw  = (CYLINDERS > 1) ? $clog2(CYLINDERS) : 1;
  localparam int unsigned HintW  = $clog2(CYLINDERS + 1);
  localparam int unsigned TrkAw  = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int unsigned SecAw  = (SECTORS > 1) ? $clog2(SECTORS) : 1;
  localparam int unsigned BitAw  = (RowW > 1) ? $clog2(RowW) : 1;
  localparam int unsigned CylW   = bdba_pkg::CylW;
  localparam int unsigned TrackW = bdba_pkg::TrackW;
  localparam int unsigned SecW   = bdba_pkg::SectorW;
  localparam int unsigned AddrW  = bdba_pkg::AddrW;
  localparam int unsigned DataW  = bdba_pkg::DataW;

  typedef enum logic [2:0] {
    StClear = 3'b001,
    StIdle  = 3'b010,
    StLook  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [RowW-1:0] map_mem [CYLINDERS];
  logic [RowW-1:0] rdata_q;
  logic            ren;
  logic [CylAw-1:0] raddr;
  logic            wen;
  logic [CylAw-1:0] waddr;
  logic [RowW-1:0] wdata;

  logic [CylAw-1:0] clr_q, clr_d;
  logic [HintW-1:0] hint_q, hint_d;
  logic [HintW-1:0] hint_inc;

  logic              req_q;
  logic [CylW-1:0]   cyl_q;
  logic [TrackW-1:0] trk_q;
  logic [SecW-1:0]   sec_q;
  logic              req_d;
  logic [CylW-1:0]   cyl_d;
  logic [TrackW-1:0] trk_d;
  logic [SecW-1:0]   sec_d;

  logic                 out_valid_q, out_valid_d;
  bdba_pkg::status_e    out_status_q, out_status_d;
  logic [AddrW-1:0]     out_addr_q, out_addr_d;

  logic              s_fire;
  logic              in_req;
  logic [CylW-1:0]   in_cyl;
  logic [TrackW-1:0] in_trk;
  logic [SecW-1:0]   in_sec;
  logic              in_range;

  logic              found;
  logic [TrkAw-1:0]  f_trk;
  logic [SecAw-1:0]  f_sec;
  logic [BitAw-1:0]  f_bit;
  logic [BitAw-1:0]  q_bit;
  logic [RowW-1:0]   q_mask;
  logic [RowW-1:0]   f_mask;

  assign in_req = s_axis_tuser_i;
  assign in_cyl = s_axis_tdata_i[CylW-1:0];
  assign in_trk = s_axis_tdata_i[CylW+TrackW-1:CylW];
  assign in_sec = s_axis_tdata_i[AddrW-1:CylW+TrackW];
  assign in_range = (32'(in_cyl) < CYLINDERS) && (32'(in_trk) < TRACKS) &&
                    (32'(in_sec) < SECTORS);

  assign s_axis_tready_o = (state_q == StIdle) && (!out_valid_q || m_axis_tready_i);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign hint_inc        = hint_q + HintW'(1);

  always_comb begin
    found = 1'b0;
    f_trk = '0;
    f_sec = '0;
    for (int t = TRACKS - 1; t >= 0; t--) begin
      for (int s = SECTORS - 1; s >= 0; s--) begin
        if (!rdata_q[t * SECTORS + s]) begin
          found = 1'b1;
          f_trk = TrkAw'(t);
          f_sec = SecAw'(s);
        end
      end
    end
  end

  assign f_bit  = BitAw'(32'(f_trk) * SECTORS + 32'(f_sec));
  assign q_bit  = BitAw'(32'(trk_q) * SECTORS + 32'(sec_q));
  assign f_mask = RowW'(1) << f_bit;
  assign q_mask = RowW'(1) << q_bit;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    hint_d       = hint_q;
    req_d        = req_q;
    cyl_d        = cyl_q;
    trk_d        = trk_q;
    sec_d        = sec_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_addr_d   = out_addr_q;
    ren          = 1'b0;
    raddr        = '0;
    wen          = 1'b0;
    waddr        = '0;
    wdata        = '0;

    unique case (state_q)
      StClear: begin
        wen   = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + CylAw'(1);
        if (32'(clr_q) == CYLINDERS - 1) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (s_fire) begin
          req_d = in_req;
          cyl_d = in_cyl;
          trk_d = in_trk;
          sec_d = in_sec;
          if (in_req == bdba_pkg::ReqAlloc) begin
            if (32'(hint_q) >= CYLINDERS) begin
              out_valid_d  = 1'b1;
              out_status_d = bdba_pkg::StFull;
              out_addr_d   = '0;
            end else begin
              ren     = 1'b1;
              raddr   = CylAw'(hint_q);
              state_d = StLook;
            end
          end else if (!in_range) begin
            out_valid_d  = 1'b1;
            out_status_d = bdba_pkg::StNotAlloc;
            out_addr_d   = {in_sec, in_trk, in_cyl};
          end else begin
            ren     = 1'b1;
            raddr   = CylAw'(in_cyl);
            state_d = StLook;
          end
        end
      end
      StLook: begin
        if (req_q == bdba_pkg::ReqAlloc) begin
          if (found) begin
            wen          = 1'b1;
            waddr        = CylAw'(hint_q);
            wdata        = rdata_q | f_mask;
            out_valid_d  = 1'b1;
            out_status_d = bdba_pkg::StOk;
            out_addr_d   = {SecW'(f_sec), TrackW'(f_trk), CylW'(hint_q)};
            state_d      = StIdle;
          end else begin
            hint_d = hint_inc;
            if (32'(hint_inc) >= CYLINDERS) begin
              out_valid_d  = 1'b1;
              out_status_d = bdba_pkg::StFull;
              out_addr_d   = '0;
              state_d      = StIdle;
            end else begin
              ren   = 1'b1;
              raddr = CylAw'(hint_inc);
            end
          end
        end else begin
          out_valid_d = 1'b1;
          out_addr_d  = {sec_q, trk_q, cyl_q};
          if (!(|(rdata_q & q_mask))) begin
            out_status_d = bdba_pkg::StNotAlloc;
          end else begin
            wen          = 1'b1;
            waddr        = CylAw'(cyl_q);
            wdata        = rdata_q & ~q_mask;
            out_status_d = bdba_pkg::StOk;
            if (HintW'(cyl_q) < hint_q) begin
              hint_d = HintW'(cyl_q);
            end
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wen) begin
      map_mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ren) begin
      rdata_q <= map_mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      hint_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      hint_q      <= hint_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    cyl_q        <= cyl_d;
    trk_q        <= trk_d;
    sec_q        <= sec_d;
    out_status_q <= out_status_d;
    out_addr_q   <= out_addr_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = DataW'(out_addr_q);

endmodule
